// ===== design/cbip_pkg.sv =====
// Package for the custom base integer parser: types, codes and character constants.
// Used by cbip_front, cbip_queue, cbip_back and custom_base_integer_parser_unit.
package cbip_pkg;

  localparam int MAX_ALPHABET = 16;
  localparam int LEN_W        = 5;
  localparam int CHARS_W      = 64;
  localparam int DIGIT_W      = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1;
  localparam int VALUE_W      = 32;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_CHARS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_CHARS = 2'd2;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_MIN_PRINT = 8'd32;

  localparam logic [LEN_W-1:0] MIN_ALPHABET = 5'd2;

  typedef enum logic [2:0] {
    CLS_TERM,
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_OTHER
  } cbip_class_t;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_STOP
  } cbip_phase_t;

  typedef struct packed {
    logic [7:0]  ch;
    cbip_class_t cls;
  } cbip_entry_t;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [CHARS_W-1:0] low_chars;
    logic [CHARS_W-1:0] high_chars;
  } cbip_cfg_t;

endpackage

// ===== design/cbip_front.sv =====
// Front end: accepts text words and tags each with its character class.
// Depends on cbip_pkg; feeds cbip_queue.
module cbip_front import cbip_pkg::*; (
  input  logic        in_valid,
  input  logic [7:0]  text_byte,
  input  logic        q_full,
  output logic        in_stall,
  output logic        push,
  output cbip_entry_t push_entry
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry.ch = text_byte;
    if (text_byte == CH_NUL) begin
      push_entry.cls = CLS_TERM;
    end else if (text_byte inside {[CH_TAB:CH_CR], CH_SPACE}) begin
      push_entry.cls = CLS_SPACE;
    end else if (text_byte == CH_PLUS) begin
      push_entry.cls = CLS_PLUS;
    end else if (text_byte == CH_MINUS) begin
      push_entry.cls = CLS_MINUS;
    end else begin
      push_entry.cls = CLS_OTHER;
    end
  end

endmodule

// ===== design/cbip_queue.sv =====
// Two-entry queue between front and back end.
// Depends on cbip_pkg for the entry type.
module cbip_queue import cbip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cbip_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        q_valid,
  output cbip_entry_t head
);

  cbip_entry_t slots [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/cbip_back.sv =====
// Back end: phase machine, digit match, multiply-add and the result register.
// Depends on cbip_pkg; takes entries from cbip_queue and the config struct.
module cbip_back import cbip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cbip_cfg_t                 cfg,
  input  logic                      q_valid,
  input  cbip_entry_t               head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] parsed_value,
  output logic                      alphabet_invalid
);

  cbip_phase_t        phase;
  cbip_phase_t        phase_next;
  logic               negative_flag;
  logic               negative_flag_next;
  logic [VALUE_W-1:0] accumulator;
  logic [VALUE_W-1:0] accumulator_next;

  logic [8*MAX_ALPHABET-1:0] all_chars;
  logic [7:0]                chars [MAX_ALPHABET];
  logic [LEN_W-1:0]          used_len;
  logic                      hit;
  logic [DIGIT_W-1:0]        digit;
  logic                      bad;
  logic                      is_term;
  logic                      is_sign;
  logic [VALUE_W-1:0]        mac;

  assign all_chars = {cfg.high_chars, cfg.low_chars};
  assign used_len  = (cfg.length > LEN_W'(MAX_ALPHABET)) ? LEN_W'(MAX_ALPHABET) : cfg.length;

  assign is_term = (head.cls == CLS_TERM);
  assign is_sign = (head.cls == CLS_PLUS) || (head.cls == CLS_MINUS);

  // a terminator needs the result register free; anything else always drains
  assign pop = q_valid && (!is_term || !out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < MAX_ALPHABET; i++) begin
      chars[i] = all_chars[8*i +: 8];
    end
  end

  // first matching character wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_ALPHABET - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < used_len) && (chars[i] == head.ch)) begin
        hit   = 1'b1;
        digit = DIGIT_W'(i);
      end
    end
  end

  always_comb begin
    bad = (cfg.length < MIN_ALPHABET) || (cfg.length > LEN_W'(MAX_ALPHABET));
    for (int i = 0; i < MAX_ALPHABET; i++) begin
      if (LEN_W'(i) < cfg.length) begin
        if ((chars[i] == CH_PLUS) || (chars[i] == CH_MINUS) ||
            (chars[i] < CH_MIN_PRINT) || chars[i][7]) begin
          bad = 1'b1;
        end
        for (int k = i + 1; k < MAX_ALPHABET; k++) begin
          if ((LEN_W'(k) < cfg.length) && (chars[k] == chars[i])) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign mac = VALUE_W'(accumulator * VALUE_W'(cfg.length)) + VALUE_W'(digit);

  // next phase
  always_comb begin
    phase_next = phase;
    if (pop) begin
      if (is_term) begin
        phase_next = PH_SPACE;
      end else begin
        case (phase)
          PH_SPACE, PH_SIGN: begin
            if (phase == PH_SPACE && head.cls == CLS_SPACE) begin
              phase_next = PH_SPACE;
            end else if (is_sign) begin
              phase_next = PH_SIGN;
            end else if (hit) begin
              phase_next = PH_DIGIT;
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_DIGIT: phase_next = hit ? PH_DIGIT : PH_STOP;
          PH_STOP:  phase_next = PH_STOP;
          default:  phase_next = PH_STOP;
        endcase
      end
    end
  end

  // sign and accumulator
  always_comb begin
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    if (pop) begin
      if (is_term) begin
        negative_flag_next = 1'b0;
        accumulator_next   = '0;
      end else if (phase != PH_STOP) begin
        if ((phase == PH_SPACE) && (head.cls == CLS_SPACE)) begin
          accumulator_next = accumulator;
        end else if ((phase == PH_SPACE || phase == PH_SIGN) && is_sign) begin
          negative_flag_next = negative_flag ^ (head.cls == CLS_MINUS);
        end else if (hit) begin
          accumulator_next = mac;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SPACE;
      negative_flag <= 1'b0;
      accumulator   <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      negative_flag <= negative_flag_next;
      accumulator   <= accumulator_next;
      if (pop && is_term) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_term) begin
      alphabet_invalid <= bad;
      if (bad) begin
        parsed_value <= '0;
      end else if (negative_flag) begin
        parsed_value <= VALUE_W'(-accumulator);
      end else begin
        parsed_value <= accumulator;
      end
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && is_term) |=> (phase == PH_SPACE && accumulator == '0 && !negative_flag))
    else $error("parser state not cleared after terminator");

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STOP && !(pop && is_term)) |=> (phase == PH_STOP))
    else $error("stopped parse resumed before terminator");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alphabet_invalid) |-> (parsed_value == '0))
    else $error("invalid alphabet result is not zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(pop && is_term))
    else $error("pending result overwritten");

endmodule

// ===== design/custom_base_integer_parser_unit.sv =====
// Custom base integer parser, top level: config registers, front, queue, back.
// Depends on cbip_pkg, cbip_front, cbip_queue and cbip_back.
// A terminator word goes through the queue and, once popped, into the result register.
// Throughput: one text word per cycle while in_stall is low, set by the single multiply-add in the back end.
// A terminator waits in the queue only while a previous result is still not taken.
// Reset (rst, synchronous): clears parse state, queue, result valid and all config regs.
module custom_base_integer_parser_unit import cbip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CHARS_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                text_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] parsed_value,
  output logic                      alphabet_invalid
);

  cbip_cfg_t   cfg;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;
  cbip_entry_t push_entry;
  cbip_entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LENGTH:     cfg.length     <= cfg_data[LEN_W-1:0];
        CFG_LOW_CHARS:  cfg.low_chars  <= cfg_data;
        CFG_HIGH_CHARS: cfg.high_chars <= cfg_data;
        default:        cfg            <= cfg;
      endcase
    end
  end

  cbip_front u_front (
    .in_valid   (in_valid),
    .text_byte  (text_byte),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  cbip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head)
  );

  cbip_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .parsed_value     (parsed_value),
    .alphabet_invalid (alphabet_invalid)
  );

endmodule

// ===== bench/custom_base_integer_parser_unit_test.sv =====
// Self-checking bench for custom_base_integer_parser_unit: random text words vs. a parse predictor.
// Needs cbip_pkg and the parser RTL; drives config writes, bursty input and a stalling receiver.
`timescale 1ns / 100ps

module custom_base_integer_parser_unit_test;
  import cbip_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_BYTES  = 115;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [7:0] ASCII_TOP = 8'd127;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = {CFG_INDEX_W{1'b1}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      invalid;
  } parse_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
  typedef enum int {BAD_PLUS, BAD_MINUS, BAD_HIGH, BAD_CONTROL, BAD_REPEAT} alpha_fault_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = CFG_LENGTH;
  logic [CHARS_W-1:0]        cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                text_byte = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] parsed_value;
  logic                      alphabet_invalid;

  custom_base_integer_parser_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .text_byte        (text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .parsed_value     (parsed_value),
    .alphabet_invalid (alphabet_invalid)
  );

  // predictor copy of the registers and parse state
  logic [LEN_W-1:0]   alpha_len = '0;
  logic [CHARS_W-1:0] alpha_low = '0;
  logic [CHARS_W-1:0] alpha_high = '0;
  cbip_phase_t        pred_phase = PH_SPACE;
  logic               pred_negative = 1'b0;
  logic [VALUE_W-1:0] pred_acc = '0;

  parse_result_t expected_results [$];
  parse_result_t oldest;
  logic [7:0]    text_queue [$];
  logic [7:0]    alpha [16];

  int cycle_count = 0;
  int mismatches = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_checked = 0;
  int invalid_seen = 0;
  int alphabets_loaded = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] alpha_char(input int idx);
    return (idx < 8) ? alpha_low[8*idx +: 8] : alpha_high[8*(idx-8) +: 8];
  endfunction

  function automatic int used_radix();
    return (alpha_len > MAX_ALPHABET) ? MAX_ALPHABET : int'(alpha_len);
  endfunction

  function automatic bit alphabet_rejected();
    logic [7:0] c;
    if (alpha_len < MIN_ALPHABET || alpha_len > MAX_ALPHABET) return 1'b1;
    for (int i = 0; i < alpha_len; i++) begin
      c = alpha_char(i);
      if (c == CH_PLUS || c == CH_MINUS || c < CH_MIN_PRINT || c > ASCII_TOP) return 1'b1;
      for (int k = i + 1; k < alpha_len; k++)
        if (alpha_char(k) == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // first matching character wins
  function automatic int digit_value(input logic [7:0] b);
    for (int i = 0; i < used_radix(); i++)
      if (alpha_char(i) == b) return i;
    return -1;
  endfunction

  task automatic parse_text_byte(input logic [7:0] b);
    int d;
    parse_result_t r;
    if (b == CH_NUL) begin
      r.invalid = alphabet_rejected();
      r.value = r.invalid ? '0 : (pred_negative ? -pred_acc : pred_acc);
      expected_results.push_back(r);
      pred_phase = PH_SPACE;
      pred_negative = 1'b0;
      pred_acc = '0;
    end else if (pred_phase != PH_STOP &&
                 !(pred_phase == PH_SPACE &&
                   ((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE))) begin
      if ((pred_phase == PH_SPACE || pred_phase == PH_SIGN) &&
          (b == CH_PLUS || b == CH_MINUS)) begin
        if (b == CH_MINUS) pred_negative = ~pred_negative;
        pred_phase = PH_SIGN;
      end else begin
        d = digit_value(b);
        if (d >= 0) begin
          pred_acc = pred_acc * alpha_len + d[VALUE_W-1:0];
          pred_phase = PH_DIGIT;
        end else begin
          pred_phase = PH_STOP;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      text_byte <= '0;
      gap_left = 0;
      burst_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (text_queue.size() > 0) begin
        in_valid <= 1'b1;
        text_byte <= text_queue.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: its own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_mode_left = $urandom_range(20, 200);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        parse_text_byte(text_byte);
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (alphabet_invalid) invalid_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: value %0d invalid %0b", parsed_value,
                     alphabet_invalid);
        end else begin
          oldest = expected_results.pop_front();
          if (parsed_value !== oldest.value || alphabet_invalid !== oldest.invalid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d invalid %0b, got value %0d invalid %0b",
                       oldest.value, oldest.invalid, parsed_value, alphabet_invalid);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CHARS_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_LENGTH:     alpha_len = data[LEN_W-1:0];
      CFG_LOW_CHARS:  alpha_low = data;
      CFG_HIGH_CHARS: alpha_high = data;
      default: ;
    endcase
  endtask

  // slots past the length get junk; they must never matter
  task automatic load_alphabet(input int len_value);
    logic [CHARS_W-1:0] lo_word, hi_word, len_word;
    for (int i = len_value; i < 16; i++) alpha[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 8; i++) begin
      lo_word[8*i +: 8] = alpha[i];
      hi_word[8*i +: 8] = alpha[i+8];
    end
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len_value[LEN_W-1:0];
    write_register(CFG_HIGH_CHARS, hi_word);
    write_register(CFG_LENGTH, len_word);
    write_register(CFG_LOW_CHARS, lo_word);
    alphabets_loaded++;
  endtask

  // distinct non-sign characters from 32 to 127; optionally space and DEL as digits 0 and 1
  task automatic pick_alphabet(input bit with_extremes);
    logic [7:0] pool [$];
    logic [7:0] t;
    int j;
    for (int c = 32; c <= 127; c++)
      if (c != CH_PLUS && c != CH_MINUS &&
          !(with_extremes && (c == CH_SPACE || c == ASCII_TOP)))
        pool.push_back(c[7:0]);
    for (int i = pool.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    if (with_extremes) begin
      pool.push_front(ASCII_TOP);
      pool.push_front(CH_SPACE);
    end
    for (int i = 0; i < 16; i++) alpha[i] = pool[i];
  endtask

  task automatic queue_byte(input logic [7:0] b);
    text_queue.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
  endfunction

  function automatic logic [7:0] sign_char();
    return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
  endfunction

  function automatic logic [7:0] digit_char();
    if (used_radix() == 0) return 8'($urandom_range(1, 255));
    return alpha_char($urandom_range(0, used_radix() - 1));
  endfunction

  // whitespace, signs, digits, sometimes trailing junk, terminator
  task automatic queue_number();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) queue_byte(space_char());
    n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) queue_byte(sign_char());
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    repeat (n) queue_byte(digit_char());
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) queue_byte(8'($urandom_range(1, 255)));
    end
    queue_byte(CH_NUL);
  endtask

  // tokens in any order, including raw bytes
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: queue_byte(space_char());
        1: queue_byte(sign_char());
        2: queue_byte(digit_char());
        default: queue_byte(8'($urandom_range(1, 255)));
      endcase
    end
    queue_byte(CH_NUL);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (text_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_strings(input int budget);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      if ($urandom_range(0, 3) != 0) queue_number();
      else queue_noise();
    end
    settle();
  endtask

  initial begin : stimulus
    logic [7:0] directed_text [21];
    int n, i, j;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: empty alphabet, every result flagged
    run_strings(30);

    for (i = 0; i < 10; i++) alpha[i] = "0" + i[7:0];
    load_alphabet(10);
    directed_text = '{CH_TAB, CH_CR, CH_SPACE, CH_MINUS, CH_PLUS, CH_MINUS, "4", "2", CH_NUL,
                      CH_PLUS, CH_SPACE, "7", CH_NUL,
                      "1", 8'hFF, "2", CH_NUL,
                      CH_NUL,
                      8'h01, "5", CH_NUL};
    foreach (directed_text[k]) queue_byte(directed_text[k]);
    settle();
    run_strings(PHASE_BYTES);

    pick_alphabet(1'b0);
    load_alphabet(2);
    run_strings(PHASE_BYTES);

    pick_alphabet(1'b1);
    load_alphabet(16);
    run_strings(PHASE_BYTES);

    // leave a half-parsed number in place across the register change
    queue_byte(CH_MINUS);
    queue_byte(digit_char());
    settle();
    pick_alphabet(1'b0);
    load_alphabet($urandom_range(3, 15));
    run_strings(PHASE_BYTES);

    // lengths the validator must reject
    pick_alphabet(1'b0);
    load_alphabet(1);
    run_strings(PHASE_BYTES / 2);
    pick_alphabet(1'b0);
    load_alphabet(17);
    run_strings(PHASE_BYTES / 2);
    pick_alphabet(1'b1);
    load_alphabet(31);
    run_strings(PHASE_BYTES / 2);

    // one bad character inside the used length
    for (int f = BAD_PLUS; f <= BAD_REPEAT; f++) begin
      pick_alphabet(1'b0);
      n = $urandom_range(2, 16);
      i = $urandom_range(0, n - 1);
      case (alpha_fault_t'(f))
        BAD_PLUS:    alpha[i] = CH_PLUS;
        BAD_MINUS:   alpha[i] = CH_MINUS;
        BAD_HIGH:    alpha[i] = 8'($urandom_range(128, 255));
        BAD_CONTROL: alpha[i] = 8'($urandom_range(0, 31));
        default: begin
          j = (i + $urandom_range(1, n - 1)) % n;
          alpha[j] = alpha[i];
        end
      endcase
      load_alphabet(n);
      run_strings(PHASE_BYTES / 2);
    end

    // index with no register behind it
    write_register(CFG_UNUSED, {$urandom, $urandom});

    // receiver holds off while short strings keep coming, so the input backs up
    pick_alphabet(1'b0);
    load_alphabet(10);
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 60; i++) begin
      if ($urandom_range(0, 2) != 0) queue_byte(digit_char());
      queue_byte(CH_NUL);
    end
    settle();

    repeat (5) begin
      pick_alphabet(1'($urandom_range(0, 1)));
      load_alphabet($urandom_range(2, 16));
      run_strings(PHASE_BYTES);
    end

    settle();
    mismatches += expected_results.size();
    $display("Checked %0d results from %0d text words; %0d carried the invalid-alphabet flag.",
             results_checked, bytes_taken, invalid_seen);
    $display("Went through %0d alphabets (radix 2 to 16, bad lengths, signs, repeats, %s); %0d %s",
             alphabets_loaded, "out-of-range characters", mismatches, "mismatches seen.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
